FILE: rtl/rdi_pkg.sv
`default_nettype none

package rdi_pkg;

    // default geometry of the datapath
    localparam int COORD_WIDTH_DEF  = 32;
    localparam int MATRIX_WIDTH_DEF = 16;

    // fixed field widths of the ports
    localparam int FIELD_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int ROW_W     = 48;
    localparam int RADIUS_W  = 63;

    // configuration port
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 63'h1_0000_0000;

    typedef enum logic [2:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_CENTER_Z,
        REG_RADIUS_SQ,
        REG_ROT_ROW0,
        REG_ROT_ROW1,
        REG_ROT_ROW2
    } reg_idx_t;

endpackage

`default_nettype wire

FILE: rtl/rdi_div.sv
`default_nettype none

module rdi_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32,
    parameter int PAY_W = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    input  wire logic [PAY_W-1:0] pay_in,
    output logic                  out_valid,
    output logic [NUM_W-1:0]      quo,
    output logic [PAY_W-1:0]      pay_out
);

    // one quotient bit per stage; numerator bits shift out as quotient bits shift in
    logic             v_reg   [NUM_W];
    logic [DEN_W-1:0] r_reg   [NUM_W];
    logic [NUM_W-1:0] nq_reg  [NUM_W];
    logic [DEN_W-1:0] d_reg   [NUM_W];
    logic [PAY_W-1:0] pay_reg [NUM_W];

    logic             v_src   [NUM_W];
    logic [DEN_W-1:0] r_src   [NUM_W];
    logic [NUM_W-1:0] nq_src  [NUM_W];
    logic [DEN_W-1:0] d_src   [NUM_W];
    logic [PAY_W-1:0] pay_src [NUM_W];

    logic [DEN_W-1:0] r_next  [NUM_W];
    logic [NUM_W-1:0] nq_next [NUM_W];

    always_comb
    begin
        v_src[0]   = in_valid;
        r_src[0]   = '0;
        nq_src[0]  = num;
        d_src[0]   = den;
        pay_src[0] = pay_in;
        for (int i = 1; i < NUM_W; i++)
        begin
            v_src[i]   = v_reg[i-1];
            r_src[i]   = r_reg[i-1];
            nq_src[i]  = nq_reg[i-1];
            d_src[i]   = d_reg[i-1];
            pay_src[i] = pay_reg[i-1];
        end
    end

    always_comb
    begin
        logic [DEN_W:0] trial;
        logic           ge;
        for (int i = 0; i < NUM_W; i++)
        begin
            trial      = {r_src[i], nq_src[i][NUM_W-1]};
            ge         = trial >= {1'b0, d_src[i]};
            r_next[i]  = ge ? DEN_W'(trial - {1'b0, d_src[i]}) : DEN_W'(trial);
            nq_next[i] = {nq_src[i][NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_W; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int i = 0; i < NUM_W; i++)
            begin
                v_reg[i] <= v_src[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_W; i++)
            begin
                r_reg[i]   <= r_next[i];
                nq_reg[i]  <= nq_next[i];
                d_reg[i]   <= d_src[i];
                pay_reg[i] <= pay_src[i];
            end
        end
    end

    assign out_valid = v_reg[NUM_W-1];
    assign quo       = nq_reg[NUM_W-1];
    assign pay_out   = pay_reg[NUM_W-1];

endmodule

`default_nettype wire

FILE: rtl/ray_disk_intersection_top.sv
// Ray against oriented disk test, one ray per clock unless a held result stalls it.
// Request channel: req_valid / req_stall with req_type, origin, direction and
// the t window. Result channel: res_valid / res_stall with hit, t_value, the
// world hit point and front_face. A transaction completes on a rising edge
// with valid high and stall low.
// Disk center, squared radius and world-to-local rows must be written over the
// APB port only while no ray is in flight; the block does not enforce this.
// Reads return the stored values. There are four stages of transform, a
// restoring divider giving one quotient bit per stage (COORD_WIDTH + 16
// stages), then six stages for the hit point, radius test and world transform.
// Throughput is one ray per cycle while no held result freezes the pipeline.
// When res_stall holds back a waiting result the whole pipeline freezes and
// req_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and loads a unit disk at the origin with an
// identity rotation.
`default_nettype none

module ray_disk_intersection_top #(
    parameter int COORD_WIDTH  = rdi_pkg::COORD_WIDTH_DEF,
    parameter int MATRIX_WIDTH = rdi_pkg::MATRIX_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    output logic                                   req_stall,
    input  wire logic                              req_type,
    input  wire logic signed [rdi_pkg::FIELD_W-1:0] origin_x,
    input  wire logic signed [rdi_pkg::FIELD_W-1:0] origin_y,
    input  wire logic signed [rdi_pkg::FIELD_W-1:0] origin_z,
    input  wire logic signed [rdi_pkg::FIELD_W-1:0] dir_x,
    input  wire logic signed [rdi_pkg::FIELD_W-1:0] dir_y,
    input  wire logic signed [rdi_pkg::FIELD_W-1:0] dir_z,
    input  wire logic signed [rdi_pkg::FIELD_W-1:0] t_min,
    input  wire logic signed [rdi_pkg::FIELD_W-1:0] t_max,
    output logic                                   res_valid,
    input  wire logic                              res_stall,
    output logic                                   hit,
    output logic signed [rdi_pkg::FIELD_W-1:0]     t_value,
    output logic signed [rdi_pkg::FIELD_W-1:0]     hit_x,
    output logic signed [rdi_pkg::FIELD_W-1:0]     hit_y,
    output logic signed [rdi_pkg::FIELD_W-1:0]     hit_z,
    output logic                                   front_face,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [rdi_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [rdi_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [rdi_pkg::CFG_DATA_W-1:0]         prdata,
    output logic                                   pready
);

    localparam int FW   = rdi_pkg::FIELD_W;
    localparam int FR   = rdi_pkg::FRAC_W;
    localparam int CW   = (COORD_WIDTH > FW) ? FW : COORD_WIDTH;
    localparam int MW   = MATRIX_WIDTH;
    localparam int MF   = MW - 2;
    localparam int RLW  = FW + 1;
    localparam int PPW  = MW + RLW;
    localparam int SW   = PPW + 2;
    localparam int NW   = CW + FR;
    localparam int QW   = 2 * CW;
    localparam int HW   = (((QW - FR) > CW) ? (QW - FR) : CW) + 1;
    localparam int CPW  = MW + RLW;
    localparam int WW   = CPW + 3;
    localparam int SQW  = 2 * FW;
    localparam int SSW  = SQW + 2;
    localparam int PAYW = 6 * CW + 2 * FW + 4;

    localparam longint CMAX  = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam longint F_MAX = (64'sd1 <<< (FW - 1)) - 64'sd1;

    localparam logic [rdi_pkg::ROW_W-1:0] ROW0_RST = rdi_pkg::ROW_W'(64'd1 << MF);
    localparam logic [rdi_pkg::ROW_W-1:0] ROW1_RST = rdi_pkg::ROW_W'(64'd1 << (MF + MW));
    localparam logic [rdi_pkg::ROW_W-1:0] ROW2_RST =
        rdi_pkg::ROW_W'(64'd1 << (MF + 2 * MW));

    function automatic logic signed [MW-1:0] lane(input logic [rdi_pkg::ROW_W-1:0] row,
                                                  input int k);
        logic [63:0] x;
        x = {{(64 - rdi_pkg::ROW_W){1'b0}}, row} >> (k * MW);
        return $signed(x[MW-1:0]);
    endfunction

    function automatic logic signed [CW-1:0] sat_cw(input logic signed [SW-1:0] v);
        if (v > SW'(CMAX))
            return CW'(CMAX);
        else if (v < SW'(-CMAX - 64'sd1))
            return CW'(-CMAX - 64'sd1);
        else
            return v[CW-1:0];
    endfunction

    function automatic logic signed [FW-1:0] sat_fw(input logic signed [WW-1:0] v);
        if (v > WW'(F_MAX))
            return FW'(F_MAX);
        else if (v < WW'(-F_MAX - 64'sd1))
            return FW'(-F_MAX - 64'sd1);
        else
            return v[FW-1:0];
    endfunction

    // ---------------- configuration registers ----------------
    logic signed [FW-1:0]                 center_reg [3];
    logic [rdi_pkg::RADIUS_W-1:0]         radius_reg;
    logic [rdi_pkg::ROW_W-1:0]            rot_reg    [3];
    logic                                 cfg_wr;
    rdi_pkg::reg_idx_t                    cfg_idx;
    logic signed [MW-1:0]                 mat        [3][3];

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = rdi_pkg::reg_idx_t'(paddr[rdi_pkg::CFG_ADDR_W-1:3]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            radius_reg    <= rdi_pkg::RADIUS_RST;
            rot_reg[0]    <= ROW0_RST;
            rot_reg[1]    <= ROW1_RST;
            rot_reg[2]    <= ROW2_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                rdi_pkg::REG_CENTER_X:  center_reg[0] <= pwdata[FW-1:0];
                rdi_pkg::REG_CENTER_Y:  center_reg[1] <= pwdata[FW-1:0];
                rdi_pkg::REG_CENTER_Z:  center_reg[2] <= pwdata[FW-1:0];
                rdi_pkg::REG_RADIUS_SQ: radius_reg    <= pwdata[rdi_pkg::RADIUS_W-1:0];
                rdi_pkg::REG_ROT_ROW0:  rot_reg[0]    <= pwdata[rdi_pkg::ROW_W-1:0];
                rdi_pkg::REG_ROT_ROW1:  rot_reg[1]    <= pwdata[rdi_pkg::ROW_W-1:0];
                rdi_pkg::REG_ROT_ROW2:  rot_reg[2]    <= pwdata[rdi_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            rdi_pkg::REG_CENTER_X:  prdata = rdi_pkg::CFG_DATA_W'(unsigned'(center_reg[0]));
            rdi_pkg::REG_CENTER_Y:  prdata = rdi_pkg::CFG_DATA_W'(unsigned'(center_reg[1]));
            rdi_pkg::REG_CENTER_Z:  prdata = rdi_pkg::CFG_DATA_W'(unsigned'(center_reg[2]));
            rdi_pkg::REG_RADIUS_SQ: prdata = rdi_pkg::CFG_DATA_W'(radius_reg);
            rdi_pkg::REG_ROT_ROW0:  prdata = rdi_pkg::CFG_DATA_W'(rot_reg[0]);
            rdi_pkg::REG_ROT_ROW1:  prdata = rdi_pkg::CFG_DATA_W'(rot_reg[1]);
            rdi_pkg::REG_ROT_ROW2:  prdata = rdi_pkg::CFG_DATA_W'(rot_reg[2]);
            default:                prdata = '0;
        endcase
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                mat[r][c] = lane(rot_reg[r], c);
            end
        end
    end

    // ---------------- pipeline control ----------------
    logic adv;

    assign adv       = !(res_valid && res_stall);
    assign req_stall = !adv;

    logic s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic q_valid_reg, m1_valid_reg, h_valid_reg, m2_valid_reg, sum_valid_reg;
    logic fin_valid_reg;
    logic div_valid;

    // ---------------- stage 0: capture, subtract center ----------------
    logic signed [RLW-1:0] s0_rel_reg [3];
    logic signed [FW-1:0]  s0_dir_reg [3];
    logic                  s0_occl_reg;
    logic signed [FW-1:0]  s0_tmin_reg, s0_tmax_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_rel_reg[0] <= RLW'(origin_x) - RLW'(center_reg[0]);
            s0_rel_reg[1] <= RLW'(origin_y) - RLW'(center_reg[1]);
            s0_rel_reg[2] <= RLW'(origin_z) - RLW'(center_reg[2]);
            s0_dir_reg[0] <= dir_x;
            s0_dir_reg[1] <= dir_y;
            s0_dir_reg[2] <= dir_z;
            s0_occl_reg   <= req_type;
            s0_tmin_reg   <= t_min;
            s0_tmax_reg   <= t_max;
        end
    end

    // ---------------- stage 1: rotation products ----------------
    logic signed [PPW-1:0] s1_pp_reg [3][3];
    logic signed [PPW-1:0] s1_dp_reg [3][3];
    logic                  s1_occl_reg;
    logic signed [FW-1:0]  s1_tmin_reg, s1_tmax_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    s1_pp_reg[r][c] <= PPW'(mat[r][c]) * PPW'(s0_rel_reg[c]);
                    s1_dp_reg[r][c] <= PPW'(mat[r][c]) * PPW'(s0_dir_reg[c]);
                end
            end
            s1_occl_reg <= s0_occl_reg;
            s1_tmin_reg <= s0_tmin_reg;
            s1_tmax_reg <= s0_tmax_reg;
        end
    end

    // ---------------- stage 2: sum, scale, saturate ----------------
    logic signed [CW-1:0] s2_p_reg [3];
    logic signed [CW-1:0] s2_d_reg [3];
    logic signed [CW-1:0] s2_p_next [3];
    logic signed [CW-1:0] s2_d_next [3];
    logic                 s2_occl_reg;
    logic signed [FW-1:0] s2_tmin_reg, s2_tmax_reg;

    always_comb
    begin
        logic signed [SW-1:0] ps, ds;
        for (int r = 0; r < 3; r++)
        begin
            ps = SW'(s1_pp_reg[r][0]) + SW'(s1_pp_reg[r][1]) + SW'(s1_pp_reg[r][2]);
            ds = SW'(s1_dp_reg[r][0]) + SW'(s1_dp_reg[r][1]) + SW'(s1_dp_reg[r][2]);
            s2_p_next[r] = sat_cw(ps >>> MF);
            s2_d_next[r] = sat_cw(ds >>> MF);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_p_reg    <= s2_p_next;
            s2_d_reg    <= s2_d_next;
            s2_occl_reg <= s1_occl_reg;
            s2_tmin_reg <= s1_tmin_reg;
            s2_tmax_reg <= s1_tmax_reg;
        end
    end

    // ---------------- stage 3: divider operands ----------------
    logic [NW-1:0]   s3_num_reg;
    logic [CW-1:0]   s3_den_reg;
    logic [PAYW-1:0] s3_pay_reg;
    logic [CW-1:0]   p1_abs, d1_abs;
    logic            q_neg_next, dzero_next, front_next;

    always_comb
    begin
        p1_abs     = s2_p_reg[1][CW-1] ? CW'(-s2_p_reg[1]) : CW'(s2_p_reg[1]);
        d1_abs     = s2_d_reg[1][CW-1] ? CW'(-s2_d_reg[1]) : CW'(s2_d_reg[1]);
        // sign of -p1 / d1
        q_neg_next = (!s2_p_reg[1][CW-1] && (s2_p_reg[1] != '0)) ^ s2_d_reg[1][CW-1];
        dzero_next = (s2_d_reg[1] == '0);
        front_next = s2_d_reg[1][CW-1] || dzero_next;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_num_reg <= {p1_abs, {FR{1'b0}}};
            s3_den_reg <= d1_abs;
            s3_pay_reg <= {s2_p_reg[0], s2_p_reg[1], s2_p_reg[2],
                           s2_d_reg[0], s2_d_reg[1], s2_d_reg[2],
                           s2_occl_reg, s2_tmin_reg, s2_tmax_reg,
                           q_neg_next, dzero_next, front_next};
        end
    end

    // ---------------- divider ----------------
    logic [NW-1:0]   div_quo;
    logic [PAYW-1:0] div_pay;

    rdi_div #(
        .NUM_W (NW),
        .DEN_W (CW),
        .PAY_W (PAYW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s3_valid_reg),
        .num       (s3_num_reg),
        .den       (s3_den_reg),
        .pay_in    (s3_pay_reg),
        .out_valid (div_valid),
        .quo       (div_quo),
        .pay_out   (div_pay)
    );

    logic signed [CW-1:0] dv_p [3];
    logic signed [CW-1:0] dv_d [3];
    logic                 dv_occl, dv_neg, dv_dzero, dv_front;
    logic signed [FW-1:0] dv_tmin, dv_tmax;

    assign {dv_p[0], dv_p[1], dv_p[2], dv_d[0], dv_d[1], dv_d[2],
            dv_occl, dv_tmin, dv_tmax, dv_neg, dv_dzero, dv_front} = div_pay;

    // ---------------- stage q: saturate t, window test ----------------
    logic signed [CW-1:0] q_t_reg, q_t_next;
    logic                 q_hitw_reg, q_hitw_next;
    logic signed [CW-1:0] q_p_reg [3];
    logic signed [CW-1:0] q_d_reg [3];
    logic                 q_occl_reg, q_front_reg;

    always_comb
    begin
        logic signed [FW-1:0] t32;
        logic                 in_win;
        if (!dv_neg)
            q_t_next = (div_quo > NW'(CMAX)) ? CW'(CMAX) : div_quo[CW-1:0];
        else
            q_t_next = (div_quo > NW'(CMAX + 64'sd1)) ? CW'(-CMAX - 64'sd1)
                                                      : CW'(~div_quo[CW-1:0] + 1'b1);
        t32 = FW'(q_t_next);
        if (dv_occl)
            in_win = (t32 >= dv_tmin) && (t32 <= dv_tmax);
        else
            in_win = !q_t_next[CW-1];
        q_hitw_next = in_win && !dv_dzero;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_t_reg     <= q_t_next;
            q_hitw_reg  <= q_hitw_next;
            q_p_reg     <= dv_p;
            q_d_reg     <= dv_d;
            q_occl_reg  <= dv_occl;
            q_front_reg <= dv_front;
        end
    end

    // ---------------- stage m1: d * t ----------------
    logic signed [QW-1:0] m1_dt_reg [3];
    logic signed [CW-1:0] m1_p_reg  [3];
    logic signed [CW-1:0] m1_t_reg;
    logic                 m1_hitw_reg, m1_occl_reg, m1_front_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m1_dt_reg[i] <= QW'(q_d_reg[i]) * QW'(q_t_reg);
            end
            m1_p_reg     <= q_p_reg;
            m1_t_reg     <= q_t_reg;
            m1_hitw_reg  <= q_hitw_reg;
            m1_occl_reg  <= q_occl_reg;
            m1_front_reg <= q_front_reg;
        end
    end

    // ---------------- stage h: local hit point, magnitudes ----------------
    logic signed [RLW-1:0] h_h_reg [3];
    logic [FW-1:0]         h_a_reg [3];
    logic signed [RLW-1:0] h_h_next [3];
    logic [FW-1:0]         h_a_next [3];
    logic                  h_big_reg, h_big_next;
    logic signed [CW-1:0]  h_t_reg;
    logic                  h_hitw_reg, h_occl_reg, h_front_reg;

    always_comb
    begin
        logic signed [HW-1:0] hv;
        logic signed [HW:0]   hx;
        logic [HW:0]          habs;
        h_big_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            hv   = HW'(m1_p_reg[i]) + HW'(m1_dt_reg[i] >>> FR);
            hx   = (HW + 1)'(hv);
            habs = hx[HW] ? (HW + 1)'(-hx) : (HW + 1)'(hx);
            // a component of 2^32 or more lies outside any radius
            if ((habs >> FW) != '0)
                h_big_next = 1'b1;
            h_a_next[i] = FW'(habs);
            h_h_next[i] = RLW'(hv);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_h_reg     <= h_h_next;
            h_a_reg     <= h_a_next;
            h_big_reg   <= h_big_next;
            h_t_reg     <= m1_t_reg;
            h_hitw_reg  <= m1_hitw_reg;
            h_occl_reg  <= m1_occl_reg;
            h_front_reg <= m1_front_reg;
        end
    end

    // ---------------- stage m2: squares, inverse rotation products ----------------
    logic [SQW-1:0]        m2_sq_reg [3];
    logic signed [CPW-1:0] m2_cp_reg [3][3];
    logic                  m2_big_reg;
    logic signed [CW-1:0]  m2_t_reg;
    logic                  m2_hitw_reg, m2_occl_reg, m2_front_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m2_sq_reg[i] <= SQW'(h_a_reg[i]) * SQW'(h_a_reg[i]);
            end
            // column c of the rotation, i.e. the transpose
            for (int c = 0; c < 3; c++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    m2_cp_reg[c][r] <= CPW'(mat[r][c]) * CPW'(h_h_reg[r]);
                end
            end
            m2_big_reg   <= h_big_reg;
            m2_t_reg     <= h_t_reg;
            m2_hitw_reg  <= h_hitw_reg;
            m2_occl_reg  <= h_occl_reg;
            m2_front_reg <= h_front_reg;
        end
    end

    // ---------------- stage sum: radius sum, world point ----------------
    logic [SSW-1:0]       sum_ss_reg;
    logic signed [WW-1:0] sum_w_reg [3];
    logic signed [WW-1:0] sum_w_next [3];
    logic                 sum_big_reg;
    logic signed [CW-1:0] sum_t_reg;
    logic                 sum_hitw_reg, sum_occl_reg, sum_front_reg;

    always_comb
    begin
        logic signed [WW-1:0] cs;
        for (int c = 0; c < 3; c++)
        begin
            cs = WW'(m2_cp_reg[c][0]) + WW'(m2_cp_reg[c][1]) + WW'(m2_cp_reg[c][2]);
            sum_w_next[c] = (cs >>> MF) + WW'(center_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_ss_reg    <= SSW'(m2_sq_reg[0]) + SSW'(m2_sq_reg[1]) + SSW'(m2_sq_reg[2]);
            sum_w_reg     <= sum_w_next;
            sum_big_reg   <= m2_big_reg;
            sum_t_reg     <= m2_t_reg;
            sum_hitw_reg  <= m2_hitw_reg;
            sum_occl_reg  <= m2_occl_reg;
            sum_front_reg <= m2_front_reg;
        end
    end

    // ---------------- final stage: result register ----------------
    logic                 fin_hit_reg, fin_hit_next;
    logic signed [FW-1:0] fin_t_reg;
    logic signed [FW-1:0] fin_x_reg, fin_y_reg, fin_z_reg;
    logic                 fin_front_reg;
    logic                 fin_occl_reg;
    logic                 fin_pt;

    assign fin_hit_next = sum_hitw_reg && !sum_big_reg &&
                          (sum_ss_reg <= SSW'(radius_reg));
    assign fin_pt       = fin_hit_next && !sum_occl_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fin_hit_reg   <= fin_hit_next;
            fin_t_reg     <= fin_hit_next ? FW'(sum_t_reg) : '0;
            fin_x_reg     <= fin_pt ? sat_fw(sum_w_reg[0]) : '0;
            fin_y_reg     <= fin_pt ? sat_fw(sum_w_reg[1]) : '0;
            fin_z_reg     <= fin_pt ? sat_fw(sum_w_reg[2]) : '0;
            fin_front_reg <= fin_hit_next && sum_front_reg;
            fin_occl_reg  <= sum_occl_reg;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            q_valid_reg   <= 1'b0;
            m1_valid_reg  <= 1'b0;
            h_valid_reg   <= 1'b0;
            m2_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
            fin_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg  <= req_valid;
            s1_valid_reg  <= s0_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            q_valid_reg   <= div_valid;
            m1_valid_reg  <= q_valid_reg;
            h_valid_reg   <= m1_valid_reg;
            m2_valid_reg  <= h_valid_reg;
            sum_valid_reg <= m2_valid_reg;
            fin_valid_reg <= sum_valid_reg;
        end
    end

    assign res_valid  = fin_valid_reg;
    assign hit        = fin_hit_reg;
    assign t_value    = fin_t_reg;
    assign hit_x      = fin_x_reg;
    assign hit_y      = fin_y_reg;
    assign hit_z      = fin_z_reg;
    assign front_face = fin_front_reg;

    // ---------------- assertions ----------------
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !hit |-> t_value == '0 && hit_x == '0 && hit_y == '0 &&
                              hit_z == '0 && !front_face)
        else $error("miss result carries nonzero fields");

    a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |-> req_stall)
        else $error("request taken while result is held");

    a_intersect_t_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && hit && !fin_occl_reg |-> !t_value[FW-1])
        else $error("intersect hit with negative t");

    a_occl_no_point: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && fin_occl_reg |-> hit_x == '0 && hit_y == '0 && hit_z == '0)
        else $error("occlusion result carries a hit point");

endmodule

`default_nettype wire
